// File: sv/obpe_pkg.sv
// Shared types and constants for the oscillometric blood-pressure estimator.
package obpe_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PERIOD_W = 10;
  localparam int BEAT_W   = 11;
  localparam int RUN_W    = 24;
  localparam int RATE_W   = 16;
  localparam int DIA_W    = 18;
  localparam int CFG_W    = 16;
  localparam int OUT_W    = 64;

  localparam logic [RUN_W-1:0]    RUN_MAX   = {RUN_W{1'b1}};
  localparam logic [BEAT_W-1:0]   BEAT_MAX  = {BEAT_W{1'b1}};
  localparam logic [PERIOD_W-1:0] MS_PER_S  = 10'd1000;

  // SEC_RECIP is ceil(2^32/1000); (x*SEC_RECIP) >> SEC_SHIFT equals x/1000 for any x below 2^22.
  localparam int                 RECIP_W   = 23;
  localparam int                 SEC_SHIFT = 32;
  localparam logic [RECIP_W-1:0] SEC_RECIP = 23'd4294968;

  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 10'd120;
  localparam logic [SAMPLE_W-1:0] CEILING_RST = 16'd150;

  // Configuration register indexes.
  localparam logic CFG_PERIOD  = 1'b0;
  localparam logic CFG_CEILING = 1'b1;

  // Run summary that the tracker hands to the result sequencer.
  typedef struct packed {
    logic [BEAT_W-1:0]   beats;
    logic [SAMPLE_W-1:0] systolic;
    logic [SAMPLE_W-1:0] mean;
  } obpe_stat_t;

endpackage

// File: sv/obpe_divider.sv
// Restoring divider, one quotient bit per cycle.
module obpe_divider #(
  parameter int DIV_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dsr_r;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             ge;

  // The partial remainder shifts in the next dividend bit from the top of quo_r.
  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign ge      = ~diff[DIV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/obpe_tracker.sv
// Per-sample beat detection, run sums and systolic/mean tracking.
module obpe_tracker #(
  parameter int MAX_SAMPLES = 1024,
  parameter int IDX_W       = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic                          clear,
  input  logic [obpe_pkg::SAMPLE_W-1:0] sample,
  input  logic [obpe_pkg::SAMPLE_W-1:0] ceiling,
  output obpe_pkg::obpe_stat_t          stat,
  output logic [IDX_W-1:0]              span
);

  localparam int CNT_W = IDX_W + 1;

  logic [obpe_pkg::SAMPLE_W-1:0] prev_r;
  logic [CNT_W-1:0]              idx_r;
  logic                          rising_r;
  logic [obpe_pkg::BEAT_W-1:0]   beats_r;
  logic [IDX_W-1:0]              first_r;
  logic [IDX_W-1:0]              latest_r;
  logic [obpe_pkg::SAMPLE_W-1:0] sys_r;
  logic [obpe_pkg::RUN_W-1:0]    run_r;
  logic [obpe_pkg::RUN_W-1:0]    big_r;
  logic [obpe_pkg::SAMPLE_W-1:0] mean_r;

  logic                          room;
  logic                          active;
  logic [obpe_pkg::SAMPLE_W:0]   diff;
  logic                          fall;
  logic [CNT_W-1:0]              idx_m1;
  logic [obpe_pkg::RUN_W:0]      sum;
  logic [obpe_pkg::RUN_W-1:0]    run_nxt;

  assign room    = idx_r < CNT_W'(MAX_SAMPLES);
  assign active  = (idx_r != '0) && (sample < ceiling);
  assign diff    = {1'b0, sample} - {1'b0, prev_r};
  assign fall    = diff[obpe_pkg::SAMPLE_W];
  assign idx_m1  = idx_r - CNT_W'(1);
  assign sum     = {1'b0, run_r} + (obpe_pkg::RUN_W + 1)'(diff[obpe_pkg::SAMPLE_W-1:0]);
  assign run_nxt = sum[obpe_pkg::RUN_W] ? obpe_pkg::RUN_MAX : sum[obpe_pkg::RUN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_r <= '0;
    end else if (take && room && active && fall && rising_r && (beats_r == '0)) begin
      sys_r <= prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      prev_r   <= '0;
      idx_r    <= '0;
      rising_r <= 1'b0;
      beats_r  <= '0;
      first_r  <= '0;
      latest_r <= '0;
      run_r    <= '0;
      big_r    <= '0;
      mean_r   <= '0;
    end else if (take && room) begin
      prev_r <= sample;
      idx_r  <= idx_r + CNT_W'(1);
      if (active) begin
        if (fall) begin
          // A fall after a rise marks a beat at the previous sample.
          if (rising_r) begin
            if (beats_r == '0) begin
              first_r <= idx_m1[IDX_W-1:0];
            end
            if (beats_r != obpe_pkg::BEAT_MAX) begin
              beats_r <= beats_r + obpe_pkg::BEAT_W'(1);
            end
            latest_r <= idx_m1[IDX_W-1:0];
          end
          if (run_r > big_r) begin
            big_r  <= run_r;
            mean_r <= prev_r;
          end
          run_r    <= '0;
          rising_r <= 1'b0;
        end else begin
          run_r <= run_nxt;
          if (diff != '0) begin
            rising_r <= 1'b1;
          end
        end
      end
    end
  end

  assign stat.beats    = beats_r;
  assign stat.systolic = sys_r;
  assign stat.mean     = mean_r;
  assign span          = latest_r - first_r;

endmodule

// File: sv/oscillometric_bp_estimator.sv
// Top level of the oscillometric blood-pressure estimator: stream ports and result sequencer.
// A sample without tlast leaves the block idle and ready for the next sample.
// A sample with tlast drops in_tready while the sequencer registers the product, scales it
// by the reciprocal, then runs the one-bit-per-cycle divider, which a zero interval skips;
// DIV_W = max(clog2(MAX_SAMPLES)+1, 17). An earlier result not yet taken holds it up too.
// Synchronous active-low reset clears the run, the sequencer and the configuration registers to defaults.
module oscillometric_bp_estimator #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [obpe_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [15:0] sample
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [obpe_pkg::OUT_W-1:0]  out_tdata,  // [15:0] heart_rate_bpm, [31:16] systolic_mmhg,
                                                  // [49:32] diastolic_mmhg, [60:50] beat_count
  output logic                        out_tuser   // [0] rate_valid
);

  localparam int IDX_W   = $clog2(MAX_SAMPLES);
  localparam int PROD_W  = IDX_W + obpe_pkg::PERIOD_W;
  localparam int FULL_W  = PROD_W + obpe_pkg::RECIP_W;
  localparam int SEC_W   = FULL_W - obpe_pkg::SEC_SHIFT;
  localparam int SCALE_W = obpe_pkg::BEAT_W + 6;
  localparam int DIV_W   = (SEC_W > SCALE_W) ? SEC_W : SCALE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SEC,
    S_RATE,
    S_FIN
  } state_t;

  state_t state_r;

  logic [obpe_pkg::PERIOD_W-1:0] period_r;
  logic [obpe_pkg::SAMPLE_W-1:0] ceil_r;
  logic [PROD_W-1:0]             prod_r;
  logic [obpe_pkg::RATE_W-1:0]   rate_r;
  logic                          valid_r;
  logic                          out_valid_r;
  logic [obpe_pkg::OUT_W-1:0]    out_data_r;
  logic                          out_user_r;

  logic                          in_acc;
  logic                          clear;
  logic                          slot_free;
  obpe_pkg::obpe_stat_t          stat;
  logic [IDX_W-1:0]              span;
  logic [PROD_W-1:0]             prod;
  logic [FULL_W-1:0]             sec_full;
  logic [SEC_W-1:0]              sec;
  logic [DIV_W-1:0]              scaled;
  logic                          div_start;
  logic [DIV_W-1:0]              div_dividend;
  logic [DIV_W-1:0]              div_divisor;
  logic                          div_done;
  logic [DIV_W-1:0]              div_quo;
  logic signed [18:0]            tri_s;
  logic signed [18:0]            adj_s;
  logic [obpe_pkg::DIA_W-1:0]    dia;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign clear     = (state_r == S_FIN) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= obpe_pkg::PERIOD_RST;
      ceil_r   <= obpe_pkg::CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        obpe_pkg::CFG_PERIOD:  period_r <= cfg_wdata[obpe_pkg::PERIOD_W-1:0];
        obpe_pkg::CFG_CEILING: ceil_r   <= cfg_wdata[obpe_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  obpe_tracker #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .IDX_W       (IDX_W)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_acc),
    .clear   (clear),
    .sample  (in_tdata),
    .ceiling (ceil_r),
    .stat    (stat),
    .span    (span)
  );

  // Interval in seconds is span*period/1000; the rate is beats*60/interval.
  assign prod     = PROD_W'(span) * PROD_W'(period_r);
  assign sec_full = FULL_W'(prod_r) * FULL_W'(obpe_pkg::SEC_RECIP);
  assign sec      = sec_full[FULL_W-1:obpe_pkg::SEC_SHIFT];
  assign scaled   = DIV_W'({stat.beats, 6'b0}) - DIV_W'({stat.beats, 2'b0});

  always_comb begin
    div_start    = 1'b0;
    div_dividend = scaled;
    div_divisor  = DIV_W'(sec);
    case (state_r)
      S_SEC:   div_start = (sec != '0);
      default: ;
    endcase
  end

  obpe_divider #(
    .DIV_W (DIV_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Diastolic is (3*mean - systolic)/2 with the halving rounded toward zero.
  assign tri_s = signed'({3'b000, stat.mean}) + signed'({2'b00, stat.mean, 1'b0})
               - signed'({3'b000, stat.systolic});
  assign adj_s = tri_s + signed'({18'b0, tri_s[18]});
  assign dia   = adj_s[18:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !clear) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_tlast) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= prod;
          state_r <= S_SEC;
        end
        S_SEC: begin
          if (sec == '0) begin
            rate_r  <= '0;
            valid_r <= 1'b0;
            state_r <= S_FIN;
          end else begin
            state_r <= S_RATE;
          end
        end
        S_RATE: begin
          if (div_done) begin
            rate_r  <= (|div_quo[DIV_W-1:obpe_pkg::RATE_W]) ? {obpe_pkg::RATE_W{1'b1}}
                                                           : div_quo[obpe_pkg::RATE_W-1:0];
            valid_r <= 1'b1;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'b000, stat.beats, dia, stat.systolic, rate_r};
            out_user_r  <= valid_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: sim/obpe_checker.sv
// Checker that predicts the estimator's readings from the accepted words and compares them.
`timescale 1ns / 1ps
module obpe_checker #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [obpe_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [15:0]                in_tdata,
  input  logic                       in_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [obpe_pkg::OUT_W-1:0] out_tdata,
  input  logic                       out_tuser,
  output int                         fail_count,
  output int                         pending_count
);

  typedef struct packed {
    logic [obpe_pkg::RATE_W-1:0]   rate;
    logic [obpe_pkg::SAMPLE_W-1:0] systolic;
    logic [obpe_pkg::DIA_W-1:0]    diastolic;
    logic [obpe_pkg::BEAT_W-1:0]   beats;
    logic                          valid;
  } bp_reading_t;

  logic [obpe_pkg::PERIOD_W-1:0] period_ms;
  logic [obpe_pkg::SAMPLE_W-1:0] ceiling;
  logic [obpe_pkg::SAMPLE_W-1:0] prev_sample;
  logic [obpe_pkg::BEAT_W-1:0]   sample_no;
  logic                          rising;
  logic [obpe_pkg::BEAT_W-1:0]   beats;
  logic [obpe_pkg::BEAT_W-1:0]   first_beat;
  logic [obpe_pkg::BEAT_W-1:0]   latest_beat;
  logic [obpe_pkg::SAMPLE_W-1:0] systolic;
  logic [obpe_pkg::RUN_W-1:0]    rise_sum;
  logic [obpe_pkg::RUN_W-1:0]    best_rise;
  logic [obpe_pkg::SAMPLE_W-1:0] mean_p;

  bp_reading_t readings_due[$];
  int mismatches = 0;
  int due_n = 0;

  assign fail_count    = mismatches;
  assign pending_count = due_n;

  // Per-deflation state; the systolic value survives from one deflation to the next.
  function automatic void clear_deflation();
    prev_sample = '0;
    sample_no   = '0;
    rising      = 1'b0;
    beats       = '0;
    first_beat  = '0;
    latest_beat = '0;
    rise_sum    = '0;
    best_rise   = '0;
    mean_p      = '0;
  endfunction

  function automatic void track_sample(input logic [obpe_pkg::SAMPLE_W-1:0] s);
    int                       delta;
    logic [obpe_pkg::RUN_W:0] sum;
    if (sample_no != 0 && s < ceiling) begin
      delta = int'(s) - int'(prev_sample);
      if (delta < 0) begin
        // A fall right after a rise marks a beat at the previous sample.
        if (rising) begin
          if (beats == 0) begin
            first_beat = sample_no - 1'b1;
            systolic   = prev_sample;
          end
          if (beats != obpe_pkg::BEAT_MAX) beats = beats + 1'b1;
          latest_beat = sample_no - 1'b1;
        end
        if (rise_sum > best_rise) begin
          best_rise = rise_sum;
          mean_p    = prev_sample;
        end
        rise_sum = '0;
        rising   = 1'b0;
      end else begin
        sum      = {1'b0, rise_sum} + delta[obpe_pkg::RUN_W:0];
        rise_sum = (sum > {1'b0, obpe_pkg::RUN_MAX}) ? obpe_pkg::RUN_MAX
                                                     : sum[obpe_pkg::RUN_W-1:0];
        if (delta > 0) rising = 1'b1;
      end
    end
    prev_sample = s;
    sample_no   = sample_no + 1'b1;
  endfunction

  function automatic bp_reading_t close_deflation();
    int          interval;
    int          bpm;
    int          dia;
    bp_reading_t r;
    interval = (int'(latest_beat) - int'(first_beat)) * int'(period_ms)
               / int'(obpe_pkg::MS_PER_S);
    bpm     = 0;
    r.valid = 1'b0;
    if (interval != 0) begin
      bpm = int'(beats) * 60 / interval;
      if (bpm > 65535) bpm = 65535;
      r.valid = 1'b1;
    end
    // Integer division in SystemVerilog truncates toward zero as required.
    dia         = (3 * int'(mean_p) - int'(systolic)) / 2;
    r.rate      = bpm[obpe_pkg::RATE_W-1:0];
    r.systolic  = systolic;
    r.diastolic = dia[obpe_pkg::DIA_W-1:0];
    r.beats     = beats;
    return r;
  endfunction

  function automatic void note_field(input string field, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch_channels
    bp_reading_t got;
    bp_reading_t want;
    if (!rst_n) begin
      period_ms = obpe_pkg::PERIOD_RST;
      ceiling   = obpe_pkg::CEILING_RST;
      systolic  = '0;
      clear_deflation();
      readings_due.delete();
    end else begin
      // A reading leaving now can only come from words accepted at earlier edges.
      if (out_tvalid && out_tready) begin
        got.rate      = out_tdata[15:0];
        got.systolic  = out_tdata[31:16];
        got.diastolic = out_tdata[49:32];
        got.beats     = out_tdata[60:50];
        got.valid     = out_tuser;
        if (readings_due.size() == 0) begin
          mismatches++;
          $display("%0t: reading expected none actual %h/%b", $time, out_tdata, out_tuser);
        end else begin
          want = readings_due.pop_front();
          note_field("heart_rate_bpm", want.rate, got.rate);
          note_field("systolic_mmhg", want.systolic, got.systolic);
          note_field("diastolic_mmhg", longint'($signed(want.diastolic)),
                     longint'($signed(got.diastolic)));
          note_field("beat_count", want.beats, got.beats);
          note_field("rate_valid", want.valid, got.valid);
        end
      end
      if (cfg_we) begin
        if (cfg_addr == obpe_pkg::CFG_PERIOD) period_ms = cfg_wdata[obpe_pkg::PERIOD_W-1:0];
        else if (cfg_addr == obpe_pkg::CFG_CEILING) ceiling = cfg_wdata[obpe_pkg::SAMPLE_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        // Words past the sample limit are dropped, but a closing word still reports.
        if (sample_no < MAX_SAMPLES) track_sample(in_tdata[obpe_pkg::SAMPLE_W-1:0]);
        if (in_tlast) begin
          readings_due.push_back(close_deflation());
          clear_deflation();
        end
      end
    end
    due_n = readings_due.size();
  end

endmodule

// File: sim/tb_oscillometric_bp_estimator.sv
// Testbench top for the estimator: clock, reset, deflation stimulus and verdict.
`timescale 1ns / 1ps
module tb_oscillometric_bp_estimator;

  localparam int MAX_SAMPLES = 1024;
  localparam int RESULT_WAIT = 64;
  localparam int LONG_HOLD   = 600;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 60;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic                       cfg_addr;
  logic [obpe_pkg::CFG_W-1:0] cfg_wdata;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [15:0]                in_tdata;
  logic                       in_tlast;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [obpe_pkg::OUT_W-1:0] out_tdata;
  logic                       out_tuser;
  int                         fail_count;
  int                         pending_count;

  bit                            idling = 1'b1;
  int                            hold_req = 0;
  int                            hold_done = 0;
  int                            words_sent = 0;
  logic [obpe_pkg::SAMPLE_W-1:0] ceiling_now;

  oscillometric_bp_estimator #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  obpe_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_oscillometric_bp_estimator failed");
    $finish;
  end

  // Reading sink: short random stalls while idling, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = hold_req;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [15:0] s, input logic last);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic send_run(input logic [15:0] q[$]);
    for (int i = 0; i < q.size(); i++) send_word(q[i], i == q.size() - 1);
  endtask

  // Stop offering words and let every reading come out before going on.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (RESULT_WAIT) @(posedge clk);
  endtask

  task automatic configure(input int period, input int ceil);
    cfg_we    <= 1'b1;
    cfg_addr  <= obpe_pkg::CFG_PERIOD;
    cfg_wdata <= period[obpe_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_addr  <= obpe_pkg::CFG_CEILING;
    cfg_wdata <= ceil[obpe_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    ceiling_now = ceil[obpe_pkg::SAMPLE_W-1:0];
  endtask

  // Deflation-like run: slow decline with pulses that swell toward the middle.
  task automatic send_wave(input int n);
    logic [15:0] q[$];
    int top, level, amp, cyc, ph, swing, v;
    top   = (ceiling_now == 0) ? $urandom_range(50, 300) : int'(ceiling_now);
    level = top + $urandom_range(0, 20);
    amp   = $urandom_range(1, top / 16 + 2);
    cyc   = $urandom_range(4, 12);
    for (int k = 0; k < n; k++) begin
      ph    = k % cyc;
      swing = (ph < cyc / 2) ? ph : cyc - ph;
      v = level - (k * top) / (2 * n) + $urandom_range(0, 2)
          + swing * amp * (1 + 4 * ((k < n / 2) ? k : n - k) / (n + 1));
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      q.push_back(v[15:0]);
    end
    send_run(q);
  endtask

  task automatic send_noise(input int n);
    logic [15:0] q[$];
    int v;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 1) == 0) v = $urandom_range(0, 65535);
      else v = int'(ceiling_now) + $urandom_range(0, 60) - 30;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      q.push_back(v[15:0]);
    end
    send_run(q);
  endtask

  initial begin : stimulus
    logic [15:0] seq[$];
    int period, ceil, phase_start, len;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = obpe_pkg::CFG_PERIOD;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    ceiling_now = obpe_pkg::CEILING_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // A run of one sample forms no change at all.
    seq = '{16'd0};
    send_run(seq);
    // Two beats too close together for a rate; the full-scale sample is above the ceiling.
    seq = '{16'd80, 16'd90, 16'd85, 16'd95, 16'd100, 16'd70, 16'd65535, 16'd60};
    send_run(seq);
    // Samples just below and exactly at the ceiling.
    seq = '{16'd140, 16'd149, 16'd150, 16'd120};
    send_run(seq);
    // Falling only: no beat, so systolic stays from the run before.
    seq = '{16'd50, 16'd40, 16'd30};
    send_run(seq);
    // Flat steps add nothing to the rise sum.
    seq = '{16'd100, 16'd100, 16'd110, 16'd105};
    send_run(seq);
    // Zero sample period forces a zero interval.
    drain();
    configure(0, 65535);
    seq = '{16'd0, 16'd65535, 16'd65534, 16'd65535, 16'd1, 16'd2, 16'd1};
    send_run(seq);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase % 3)
        0:       period = 1;
        1:       period = 1000;
        default: period = $urandom_range(1, 1000);
      endcase
      case (phase % 4)
        0:       ceil = $urandom_range(100, 300);
        1:       ceil = 65535;
        2:       ceil = 0;
        default: ceil = $urandom_range(0, 65535);
      endcase
      configure(period, ceil);
      if (phase >= PHASES - 2) idling = 1'b0;
      // One run longer than the sample limit; the tail is dropped but the last word reports.
      if (phase == 1) send_wave($urandom_range(MAX_SAMPLES + 6, MAX_SAMPLES + 16));
      if (phase == 4) begin
        hold_req++;
        repeat (10) send_wave($urandom_range(2, 4));
        drain();
      end
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        if ($urandom_range(0, 9) < 7) send_wave(len);
        else send_noise(len);
      end
    end

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_oscillometric_bp_estimator passed");
    end else begin
      $display("tb_oscillometric_bp_estimator failed");
    end
    $finish;
  end

endmodule
